### rtl/bgs_pkg.sv
package bgs_pkg;

    localparam int DEFAULT_MAX_COLUMNS = 128;
    localparam int DEFAULT_MAX_ROWS    = 128;

    localparam int HEIGHT_W   = 16;
    localparam int WORLD_W    = 24;
    localparam int CELL_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int DIVIDEND_W = WORLD_W - 1 + FRAC_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0]  RESET_GRID_WIDTH = 8'd128;
    localparam logic [7:0]  RESET_GRID_DEPTH = 8'd128;
    localparam logic [15:0] RESET_SPACING    = 16'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_WIDTH = 2'd0,
        CFG_GRID_DEPTH = 2'd1,
        CFG_SPACING    = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

endpackage

### rtl/bilinear_grid_sampler.sv
// Bilinear height-grid sampler.
// Input channel (in_valid/in_stall): operation 0 writes height_value at
// (cell_row, cell_column); operation 1 samples at (world_x, world_z), Q16.8.
// Each sample yields one sampled_height transfer on out_valid/out_stall;
// writes yield none. Items are taken in order, one per unstalled cycle.
// Front: input register plus 31-stage pipelined divider (world << 8 / cell
// spacing) and clamp; a 4-entry queue; back: four parity banks read in
// parallel into registers, then four blend stages.
// Throughput is one item per cycle while neither side stalls, set by the
// divider pipeline and one read per bank per cycle.
// Config port (cfg_valid/cfg_ready, always ready): index 0 grid_width,
// 1 grid_depth, 2 cell spacing; write only while idle.
// Reset: registers go to 128, 128, 256; pipeline empties. Grid contents are
// undefined until written.
// When out_stall holds while out_valid is high, the back end freezes, the
// queue fills, and then in_stall rises; no transfer is lost.
module bilinear_grid_sampler #(
    parameter int MAX_COLUMNS = bgs_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = bgs_pkg::DEFAULT_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [6:0]                          cell_column,
    input  logic [6:0]                          cell_row,
    input  logic signed [15:0]                  height_value,
    input  logic signed [23:0]                  world_x,
    input  logic signed [23:0]                  world_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [15:0]                  sampled_height,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bgs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int EW = 2 + 2 * CW + 2 * RW + 16 + 16;

    logic [7:0]  grid_width_reg;
    logic [7:0]  grid_depth_reg;
    logic [15:0] spacing_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= bgs_pkg::RESET_GRID_WIDTH;
            grid_depth_reg <= bgs_pkg::RESET_GRID_DEPTH;
            spacing_reg    <= bgs_pkg::RESET_SPACING;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bgs_pkg::cfg_index_t'(cfg_index))
                bgs_pkg::CFG_GRID_WIDTH: grid_width_reg <= cfg_data[7:0];
                bgs_pkg::CFG_GRID_DEPTH: grid_depth_reg <= cfg_data[7:0];
                bgs_pkg::CFG_SPACING:    spacing_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic          push, pop, q_full, q_empty;
    logic [EW-1:0] push_data, pop_data;

    bgs_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .EW          (EW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .cell_column  (cell_column),
        .cell_row     (cell_row),
        .height_value (height_value),
        .world_x      (world_x),
        .world_z      (world_z),
        .grid_width   (grid_width_reg),
        .grid_depth   (grid_depth_reg),
        .grid_spacing (spacing_reg),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    bgs_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    bgs_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .EW          (EW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_data       (pop_data),
        .q_empty        (q_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sampled_height (sampled_height)
    );

endmodule

### rtl/bgs_queue.sv
module bgs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = bgs_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/bgs_front.sv
module bgs_front #(
    parameter int MAX_COLUMNS = bgs_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = bgs_pkg::DEFAULT_MAX_ROWS,
    parameter int EW          = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [6:0]           cell_column,
    input  logic [6:0]           cell_row,
    input  logic signed [15:0]   height_value,
    input  logic signed [23:0]   world_x,
    input  logic signed [23:0]   world_z,
    input  logic [7:0]           grid_width,
    input  logic [7:0]           grid_depth,
    input  logic [15:0]          grid_spacing,
    output logic                 push,
    output logic [EW-1:0]        push_data,
    input  logic                 q_full
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int WW = $clog2(MAX_COLUMNS + 1);
    localparam int DW = $clog2(MAX_ROWS + 1);
    localparam int NB = bgs_pkg::DIVIDEND_W;
    localparam int SW = bgs_pkg::CELL_W;
    localparam int FW = bgs_pkg::FRAC_W;
    localparam int WORLD_HI = bgs_pkg::WORLD_W - 1;

    logic          adv;
    logic [WW-1:0] w_eff;
    logic [DW-1:0] d_eff;
    logic [SW-1:0] cs_eff;

    logic          valid_reg  [NB+1];
    logic          op_reg     [NB+1];
    logic          wen_reg    [NB+1];
    logic [CW-1:0] col_reg    [NB+1];
    logic [RW-1:0] row_reg    [NB+1];
    logic [15:0]   height_reg [NB+1];
    logic [SW-1:0] rem_x_reg  [NB+1];
    logic [NB-1:0] num_x_reg  [NB+1];
    logic [NB-1:0] quo_x_reg  [NB+1];
    logic [SW-1:0] rem_z_reg  [NB+1];
    logic [NB-1:0] num_z_reg  [NB+1];
    logic [NB-1:0] quo_z_reg  [NB+1];

    assign adv      = !q_full;
    assign in_stall = q_full;

    always_comb
    begin
        if (grid_width == 8'd0)
            w_eff = WW'(1);
        else if (32'(grid_width) > MAX_COLUMNS)
            w_eff = WW'(MAX_COLUMNS);
        else
            w_eff = WW'(grid_width);
        if (grid_depth == 8'd0)
            d_eff = DW'(1);
        else if (32'(grid_depth) > MAX_ROWS)
            d_eff = DW'(MAX_ROWS);
        else
            d_eff = DW'(grid_depth);
        cs_eff = (grid_spacing == '0) ? SW'(1) : grid_spacing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (adv)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0]     <= operation;
            wen_reg[0]    <= (32'(cell_column) < MAX_COLUMNS) && (32'(cell_row) < MAX_ROWS);
            col_reg[0]    <= CW'(cell_column);
            row_reg[0]    <= RW'(cell_row);
            height_reg[0] <= height_value;
            rem_x_reg[0]  <= '0;
            quo_x_reg[0]  <= '0;
            num_x_reg[0]  <= (world_x > 0) ? {world_x[WORLD_HI-1:0], FW'(0)} : '0;
            rem_z_reg[0]  <= '0;
            quo_z_reg[0]  <= '0;
            num_z_reg[0]  <= (world_z > 0) ? {world_z[WORLD_HI-1:0], FW'(0)} : '0;
        end
    end

    for (genvar k = 1; k <= NB; k++)
    begin : g_div
        logic [SW:0] tx, tz;

        assign tx = {rem_x_reg[k-1], num_x_reg[k-1][NB-1]};
        assign tz = {rem_z_reg[k-1], num_z_reg[k-1][NB-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                op_reg[k]     <= op_reg[k-1];
                wen_reg[k]    <= wen_reg[k-1];
                col_reg[k]    <= col_reg[k-1];
                row_reg[k]    <= row_reg[k-1];
                height_reg[k] <= height_reg[k-1];
                num_x_reg[k]  <= num_x_reg[k-1] << 1;
                num_z_reg[k]  <= num_z_reg[k-1] << 1;
                if (tx >= {1'b0, cs_eff})
                begin
                    rem_x_reg[k] <= SW'(tx - {1'b0, cs_eff});
                    quo_x_reg[k] <= {quo_x_reg[k-1][NB-2:0], 1'b1};
                end
                else
                begin
                    rem_x_reg[k] <= SW'(tx);
                    quo_x_reg[k] <= {quo_x_reg[k-1][NB-2:0], 1'b0};
                end
                if (tz >= {1'b0, cs_eff})
                begin
                    rem_z_reg[k] <= SW'(tz - {1'b0, cs_eff});
                    quo_z_reg[k] <= {quo_z_reg[k-1][NB-2:0], 1'b1};
                end
                else
                begin
                    rem_z_reg[k] <= SW'(tz);
                    quo_z_reg[k] <= {quo_z_reg[k-1][NB-2:0], 1'b0};
                end
            end
        end
    end

    logic [CW+FW-1:0] top_x, gx;
    logic [RW+FW-1:0] top_z, gz;
    logic [CW-1:0]    ix0, ix1;
    logic [RW-1:0]    iz0, iz1;
    logic [FW-1:0]    fx, fz;

    always_comb
    begin
        top_x = {CW'(w_eff - WW'(1)), FW'(0)};
        top_z = {RW'(d_eff - DW'(1)), FW'(0)};
        gx = (quo_x_reg[NB] > NB'(top_x)) ? top_x : (CW+FW)'(quo_x_reg[NB]);
        gz = (quo_z_reg[NB] > NB'(top_z)) ? top_z : (RW+FW)'(quo_z_reg[NB]);
        if (op_reg[NB] == bgs_pkg::OP_SAMPLE)
        begin
            ix0 = gx[CW+FW-1:FW];
            iz0 = gz[RW+FW-1:FW];
            fx  = gx[FW-1:0];
            fz  = gz[FW-1:0];
            ix1 = (32'(ix0) + 1 < 32'(w_eff)) ? ix0 + CW'(1) : ix0;
            iz1 = (32'(iz0) + 1 < 32'(d_eff)) ? iz0 + RW'(1) : iz0;
        end
        else
        begin
            ix0 = col_reg[NB];
            ix1 = col_reg[NB];
            iz0 = row_reg[NB];
            iz1 = row_reg[NB];
            fx  = '0;
            fz  = '0;
        end
    end

    assign push      = adv && valid_reg[NB];
    assign push_data = {op_reg[NB], wen_reg[NB], ix0, ix1, iz0, iz1, fx, fz, height_reg[NB]};

endmodule

### rtl/bgs_back.sv
module bgs_back #(
    parameter int MAX_COLUMNS = bgs_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = bgs_pkg::DEFAULT_MAX_ROWS,
    parameter int EW          = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [EW-1:0]       pop_data,
    input  logic                q_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  sampled_height
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CHW = (CW > 1) ? CW - 1 : 1;
    localparam int RHW = (RW > 1) ? RW - 1 : 1;
    localparam int BD  = 2 ** (CHW + RHW);

    logic          e_op, e_wen;
    logic [CW-1:0] e_ix0, e_ix1;
    logic [RW-1:0] e_iz0, e_iz1;
    logic [7:0]    e_fx, e_fz;
    logic [15:0]   e_height;
    logic          adv, wr_en, smp;

    assign {e_op, e_wen, e_ix0, e_ix1, e_iz0, e_iz1, e_fx, e_fz, e_height} = pop_data;

    logic                out_valid_reg;
    logic signed [15:0]  out_reg;

    assign adv   = !(out_valid_reg && out_stall);
    assign pop   = adv && !q_empty;
    assign smp   = !q_empty && (e_op == bgs_pkg::OP_SAMPLE);
    assign wr_en = pop && (e_op == bgs_pkg::OP_WRITE) && e_wen;

    logic signed [15:0] rd_reg [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PR = 1'((b >> 1) & 1);
        localparam logic PC = 1'(b & 1);

        logic [15:0]          mem [BD];
        logic [RW-1:0]        rsel;
        logic [CW-1:0]        csel;
        logic [RHW+CHW-1:0]   addr;

        assign rsel = (e_iz0[0] == PR) ? e_iz0 : e_iz1;
        assign csel = (e_ix0[0] == PC) ? e_ix0 : e_ix1;
        assign addr = {RHW'(rsel >> 1), CHW'(csel >> 1)};

        always_ff @(posedge clk)
        begin
            if (wr_en && e_iz0[0] == PR && e_ix0[0] == PC)
                mem[addr] <= e_height;
            if (adv)
                rd_reg[b] <= mem[addr];
        end
    end

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]         sp0_reg, sr0_reg, sp1_reg, sr1_reg;
    logic [7:0]         fx1_reg, fz1_reg, fz2_reg, fz3_reg;
    logic signed [15:0] p0_reg, p1_reg;
    logic signed [25:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [16:0] a_reg, b_reg, a4_reg;

    logic signed [15:0] p0, r0, p1, r1;
    logic signed [16:0] d0, d1, d2, res;

    always_comb
    begin
        p0  = rd_reg[sp0_reg];
        r0  = rd_reg[sr0_reg];
        p1  = rd_reg[sp1_reg];
        r1  = rd_reg[sr1_reg];
        d0  = 17'(r0) - 17'(p0);
        d1  = 17'(r1) - 17'(p1);
        d2  = b_reg - a_reg;
        res = a4_reg + 17'(prod2_reg >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= smp;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp0_reg   <= {e_iz0[0], e_ix0[0]};
            sr0_reg   <= {e_iz0[0], e_ix1[0]};
            sp1_reg   <= {e_iz1[0], e_ix0[0]};
            sr1_reg   <= {e_iz1[0], e_ix1[0]};
            fx1_reg   <= e_fx;
            fz1_reg   <= e_fz;
            p0_reg    <= p0;
            p1_reg    <= p1;
            prod0_reg <= d0 * $signed({1'b0, fx1_reg});
            prod1_reg <= d1 * $signed({1'b0, fx1_reg});
            fz2_reg   <= fz1_reg;
            a_reg     <= 17'(p0_reg) + 17'(prod0_reg >>> 8);
            b_reg     <= 17'(p1_reg) + 17'(prod1_reg >>> 8);
            fz3_reg   <= fz2_reg;
            a4_reg    <= a_reg;
            prod2_reg <= d2 * $signed({1'b0, fz3_reg});
            out_reg   <= 16'(res);
        end
    end

    assign out_valid      = out_valid_reg;
    assign sampled_height = out_reg;

endmodule

### tb/sv/tb_bilinear_grid_sampler.sv
module tb_bilinear_grid_sampler;
    import bgs_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE = 60;
    localparam int RAND_PER_PHASE = 185;
    localparam int NUM_PHASES = 7;

    typedef struct {
        op_t                op;
        logic [6:0]         col;
        logic [6:0]         row;
        logic signed [15:0] h;
        logic signed [23:0] x;
        logic signed [23:0] z;
        bit                 known;
        logic signed [15:0] height;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic operation;
    logic [6:0] cell_column;
    logic [6:0] cell_row;
    logic signed [15:0] height_value;
    logic signed [23:0] world_x;
    logic signed [23:0] world_z;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] sampled_height;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    logic signed [15:0] grid_h [128][128];
    bit written [128][128];
    logic [7:0] width_reg;
    logic [7:0] depth_reg;
    logic [15:0] cell_reg;

    logic signed [15:0] height_q [$];
    int errors = 0;
    int samples_checked = 0;
    int writes_sent = 0;
    int items_sent = 0;
    int cfg_writes = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int start_sent = 0;
    int step = 0;
    bit hold_req = 0;
    int hold_left = 0;

    bilinear_grid_sampler uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .cell_column(cell_column), .cell_row(cell_row),
        .height_value(height_value), .world_x(world_x), .world_z(world_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .sampled_height(sampled_height),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_bilinear_grid_sampler: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (height_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, sampled_height %0d", $time, sampled_height);
                errors++;
            end
            else
            begin
                if (sampled_height !== height_q[0])
                begin
                    $display("%0t: sampled_height expected %0d actual %0d",
                             $time, height_q[0], sampled_height);
                    errors++;
                end
                void'(height_q.pop_front());
                samples_checked++;
            end
        end
    end

    function automatic int unsigned eff_size(logic [7:0] v);
        if (v == 0)
            return 1;
        if (v > 128)
            return 128;
        return 32'(v);
    endfunction

    function automatic int unsigned grid_coord(logic signed [23:0] w, int unsigned lim,
                                               int unsigned cs);
        longint unsigned q;
        longint unsigned top;
        if (w <= 0)
            return 0;
        q = (longint'(w) << 8) / cs;
        top = longint'(lim - 1) << 8;
        return (q > top) ? 32'(top) : 32'(q);
    endfunction

    function automatic int blend(int p, int r, int f);
        return p + (((r - p) * f) >>> 8);
    endfunction

    function automatic void locate(input logic signed [23:0] x, input logic signed [23:0] z,
                                   output int ix0, output int ix1, output int iz0,
                                   output int iz1, output int fx, output int fz);
        int unsigned ew;
        int unsigned ed;
        int unsigned cs;
        int unsigned gx;
        int unsigned gz;
        ew = eff_size(width_reg);
        ed = eff_size(depth_reg);
        cs = (cell_reg == 0) ? 1 : 32'(cell_reg);
        gx = grid_coord(x, ew, cs);
        gz = grid_coord(z, ed, cs);
        ix0 = int'(gx >> 8);
        iz0 = int'(gz >> 8);
        fx = int'(gx & 32'hFF);
        fz = int'(gz & 32'hFF);
        ix1 = (ix0 + 1 < ew) ? ix0 + 1 : ix0;
        iz1 = (iz0 + 1 < ed) ? iz0 + 1 : iz0;
    endfunction

    function automatic logic signed [15:0] interpolate(logic signed [23:0] x,
                                                       logic signed [23:0] z);
        int ix0, ix1, iz0, iz1, fx, fz, a, b;
        locate(x, z, ix0, ix1, iz0, iz1, fx, fz);
        a = blend(grid_h[iz0][ix0], grid_h[iz0][ix1], fx);
        b = blend(grid_h[iz1][ix0], grid_h[iz1][ix1], fx);
        return 16'(blend(a, b, fz));
    endfunction

    task automatic send(input row_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= it.op;
        cell_column <= it.col;
        cell_row <= it.row;
        height_value <= it.h;
        world_x <= it.x;
        world_z <= it.z;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        items_sent++;
        if (it.op == OP_WRITE)
        begin
            grid_h[it.row][it.col] = it.h;
            written[it.row][it.col] = 1;
            writes_sent++;
        end
        else
        begin
            height_q.push_back(it.known ? it.height : interpolate(it.x, it.z));
        end
    endtask

    function automatic row_t noise_item(op_t op);
        row_t it;
        it.op = op;
        it.col = 7'($urandom);
        it.row = 7'($urandom);
        it.h = 16'($urandom);
        it.x = 24'($urandom);
        it.z = 24'($urandom);
        it.known = 0;
        it.height = 0;
        return it;
    endfunction

    task automatic fill_cell(int r, int c);
        row_t it;
        if (!written[r][c])
        begin
            it = noise_item(OP_WRITE);
            it.row = 7'(r);
            it.col = 7'(c);
            send(it);
        end
    endtask

    // any entry the sample would touch gets written first
    task automatic sample_item(input row_t it);
        int ix0, ix1, iz0, iz1, fx, fz;
        locate(it.x, it.z, ix0, ix1, iz0, iz1, fx, fz);
        fill_cell(iz0, ix0);
        fill_cell(iz0, ix1);
        fill_cell(iz1, ix0);
        fill_cell(iz1, ix1);
        send(it);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_GRID_WIDTH: width_reg = data[7:0];
            CFG_GRID_DEPTH: depth_reg = data[7:0];
            CFG_SPACING:    cell_reg = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (height_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_pos(logic [7:0] size_reg);
        longint span;
        if ($urandom_range(99) < 20)
            return 24'($urandom);
        if ($urandom_range(99) < 10)
            return -$signed({1'b0, 23'($urandom_range(0, 4000))});
        span = longint'(eff_size(size_reg) + 1) * ((cell_reg == 0) ? 1 : cell_reg);
        if (span > 24'h7FFFFF)
            span = 24'h7FFFFF;
        return 24'($urandom_range(0, 32'(span)));
    endfunction

    row_t plan [$];
    row_t it;
    logic [7:0]  phase_w [NUM_PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd5, 8'd128, 8'd17};
    logic [7:0]  phase_d [NUM_PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd3, 8'd1, 8'd128};
    logic [15:0] phase_c [NUM_PHASES] =
        '{16'd256, 16'd1, 16'd0, 16'hFFFF, 16'd100, 16'd384, 16'd1};

    function automatic row_t drow(op_t op, int c, int r, int h, int x, int z,
                                  bit known, int height);
        row_t d;
        d = noise_item(op);
        if (op == OP_WRITE)
        begin
            d.col = 7'(c);
            d.row = 7'(r);
            d.h = 16'(h);
        end
        else
        begin
            d.x = 24'(x);
            d.z = 24'(z);
        end
        d.known = known;
        d.height = 16'(height);
        return d;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = 1'b0;
        cell_column = '0;
        cell_row = '0;
        height_value = '0;
        world_x = '0;
        world_z = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        width_reg = RESET_GRID_WIDTH;
        depth_reg = RESET_GRID_DEPTH;
        cell_reg = RESET_SPACING;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(drow(OP_WRITE, 0, 0, -32768, 0, 0, 0, 0));
        plan.push_back(drow(OP_WRITE, 1, 0, -32768, 0, 0, 0, 0));
        plan.push_back(drow(OP_WRITE, 0, 1, -32768, 0, 0, 0, 0));
        plan.push_back(drow(OP_WRITE, 1, 1, -32768, 0, 0, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, -8388608, -1, 1, -32768));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 0, 0, 1, -32768));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 128, 128, 1, -32768));
        plan.push_back(drow(OP_WRITE, 127, 127, 32767, 0, 0, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 8388607, 8388607, 1, 32767));
        plan.push_back(drow(OP_WRITE, 127, 0, 16'h0101, 0, 0, 0, 0));
        plan.push_back(drow(OP_WRITE, 127, 1, 16'h7F00, 0, 0, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 8388607, 0, 1, 16'h0101));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 8388607, 200, 0, 0));
        plan.push_back(drow(OP_WRITE, 2, 0, 32767, 0, 0, 0, 0));
        plan.push_back(drow(OP_WRITE, 2, 1, 0, 0, 0, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 255, 255, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 383, 1, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 32767, -8388608, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 126 * 256 + 255, 126 * 256 + 1, 0, 0));
        plan.push_back(drow(OP_SAMPLE, 0, 0, 0, 1, 127 * 256, 0, 0));
        foreach (plan[i])
        begin
            if (plan[i].op == OP_WRITE)
                send(plan[i]);
            else
                sample_item(plan[i]);
        end
        drain();
        write_reg(CFG_UNUSED, 16'($urandom));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                write_reg(CFG_GRID_WIDTH, {8'h00, phase_w[p]});
                write_reg(CFG_GRID_DEPTH, {8'h00, phase_d[p]});
                write_reg(CFG_SPACING, phase_c[p]);
            end
            if (p < 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 88;
            end
            else if (p < 5)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            start_sent = items_sent;
            step = 0;
            while (items_sent - start_sent < RAND_PER_PHASE)
            begin
                if (p == 1 && step == 60)
                    hold_req = 1;
                if (p == 2 && step == 100)
                    drain();
                if ($urandom_range(99) < 25)
                begin
                    send(noise_item(OP_WRITE));
                end
                else
                begin
                    it = noise_item(OP_SAMPLE);
                    it.x = random_pos(width_reg);
                    it.z = random_pos(depth_reg);
                    sample_item(it);
                end
                step++;
            end
        end
        drain();

        $display("covered %0d checked samples, %0d height writes, %0d register writes",
                 samples_checked, writes_sent, cfg_writes);
        $display("grid settings from 1x1 to oversized, cell sizes 0..65535, stalls both sides");
        if (errors == 0)
            $display("tb_bilinear_grid_sampler: PASS");
        else
            $display("tb_bilinear_grid_sampler: FAIL");
        $finish;
    end

endmodule
